// ===== rtl/aes_ctr_block_cipher_macros.svh =====
// Assertion macros for the AES counter-mode block.
`ifndef AES_CTR_BLOCK_CIPHER_MACROS_SVH
`define AES_CTR_BLOCK_CIPHER_MACROS_SVH

// Same-cycle implication.
`define ACBC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("acbc assertion failed");

// Next-cycle implication.
`define ACBC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("acbc assertion failed");

`endif

// ===== rtl/acbc_pkg.sv =====
// Types, constants and AES round functions shared by the counter-mode block.
package acbc_pkg;

    localparam logic [1:0] MODE_128 = 2'd0;
    localparam logic [1:0] MODE_192 = 2'd1;
    localparam logic [1:0] MODE_256 = 2'd2;

    localparam logic [2:0] CFG_KEY0  = 3'd0;
    localparam logic [2:0] CFG_KEY1  = 3'd1;
    localparam logic [2:0] CFG_KEY2  = 3'd2;
    localparam logic [2:0] CFG_KEY3  = 3'd3;
    localparam logic [2:0] CFG_NONCE = 3'd4;
    localparam logic [2:0] CFG_MODE  = 3'd5;

    localparam int NUM_ROUNDS_MAX = 14;

    typedef struct packed {
        logic [63:0] block_index;
        logic [63:0] data_lo;
        logic [63:0] data_hi;
        logic        last_block;
    } src_req_t;

    typedef struct packed {
        logic [63:0] out_lo;
        logic [63:0] out_hi;
        logic        out_last;
    } dst_req_t;

    // One pipeline slot: cipher state, key schedule window and passenger data.
    typedef struct packed {
        logic [127:0]      state;
        logic [7:0][31:0]  kw;
        logic [2:0]        kidx;
        logic [7:0]        rcon;
        logic [63:0]       data_lo;
        logic [63:0]       data_hi;
        logic              last;
    } stage_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [7:0] xtime(input logic [7:0] b);
        return b[7] ? ({b[6:0], 1'b0} ^ 8'h1b) : {b[6:0], 1'b0};
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    // SubBytes and ShiftRows; byte n of the state sits at bits 8n+7:8n.
    function automatic logic [127:0] sub_shift(input logic [127:0] s);
        logic [127:0] t;
        t = '0;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[8*(r+4*c) +: 8] = SBOX[s[8*(r+4*((c+r)%4)) +: 8]];
            end
        end
        return t;
    endfunction

    function automatic logic [127:0] mix_columns(input logic [127:0] t);
        logic [127:0] s;
        logic [7:0]   a0, a1, a2, a3, all;
        s = '0;
        for (int c = 0; c < 4; c++) begin
            a0  = t[32*c +: 8];
            a1  = t[32*c+8 +: 8];
            a2  = t[32*c+16 +: 8];
            a3  = t[32*c+24 +: 8];
            all = a0 ^ a1 ^ a2 ^ a3;
            s[32*c +: 8]    = a0 ^ all ^ xtime(a0 ^ a1);
            s[32*c+8 +: 8]  = a1 ^ all ^ xtime(a1 ^ a2);
            s[32*c+16 +: 8] = a2 ^ all ^ xtime(a2 ^ a3);
            s[32*c+24 +: 8] = a3 ^ all ^ xtime(a3 ^ a0);
        end
        return s;
    endfunction

    // Current round key from the schedule window, by key size.
    function automatic logic [127:0] round_key(input logic [7:0][31:0] w, input logic [1:0] mode);
        logic [127:0] rk;
        case (mode)
            MODE_128: rk = w[7:4];
            MODE_192: rk = w[5:2];
            default:  rk = w[3:0];
        endcase
        return rk;
    endfunction

endpackage

// ===== rtl/acbc_round_stage.sv =====
// One AES round with four words of on-the-fly key expansion, registered.
module acbc_round_stage (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic [1:0]      mode,
    input  logic [3:0]      round_num,
    input  logic            src_valid,
    input  acbc_pkg::stage_t src_stage,
    output logic            dst_valid,
    output acbc_pkg::stage_t dst_stage
);
    import acbc_pkg::*;

    logic [7:0][31:0] w;
    logic [31:0]      temp;
    logic [31:0]      nw;
    logic [2:0]       idx;
    logic [2:0]       last_idx;
    logic [7:0]       rc;
    logic [3:0]       nr;
    logic [127:0]     rk;
    logic [127:0]     sb;
    stage_t           stage_next;
    logic             valid_reg;
    stage_t           stage_reg;

    always_comb
    begin
        case (mode)
            MODE_128: begin last_idx = 3'd3; nr = 4'd10; end
            MODE_192: begin last_idx = 3'd5; nr = 4'd12; end
            default:  begin last_idx = 3'd7; nr = 4'd14; end
        endcase

        w   = src_stage.kw;
        idx = src_stage.kidx;
        rc  = src_stage.rcon;
        for (int k = 0; k < 4; k++) begin
            temp = w[7];
            if (idx == 3'd0)
            begin
                temp = sub_word({temp[7:0], temp[31:8]}) ^ {24'd0, rc};
                rc   = xtime(rc);
            end
            else if (mode == MODE_256 && idx == 3'd4)
            begin
                temp = sub_word(temp);
            end
            case (mode)
                MODE_128: nw = w[4] ^ temp;
                MODE_192: nw = w[2] ^ temp;
                default:  nw = w[0] ^ temp;
            endcase
            w   = {nw, w[7:1]};
            idx = (idx == last_idx) ? 3'd0 : idx + 3'd1;
        end

        rk = round_key(w, mode);
        sb = sub_shift(src_stage.state);

        stage_next      = src_stage;
        stage_next.kw   = w;
        stage_next.kidx = idx;
        stage_next.rcon = rc;
        if (round_num < nr)
            stage_next.state = mix_columns(sb) ^ rk;
        else if (round_num == nr)
            stage_next.state = sb ^ rk;
        else
            stage_next.state = src_stage.state;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= src_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            stage_reg <= stage_next;
    end

    assign dst_valid = valid_reg;
    assign dst_stage = stage_reg;

endmodule

// ===== rtl/aes_ctr_block_cipher.sv =====
// AES counter-mode block cipher (128/192/256-bit keys), fully pipelined.
//
// Requests on src carry block_index, two 64-bit data halves and last_block;
// each one yields exactly one request on dst holding data XOR key stream.
// The key stream block is AES of {nonce, block_index}, little-endian bytes.
// Both channels use valid/stall: a request moves when valid is high and
// stall is low.
// Key words, nonce and key size are written through cfg_we/cfg_index/cfg_data;
// index 5 selects the key size (3 acts as 256). The user must write them only
// while no request is in flight; the block does not enforce this. A request
// passes one stage for the counter and initial key add, then fourteen round
// stages, each holding its own slice of the key expansion. Shorter keys pass
// the remaining stages unchanged, so latency does not depend on key size.
// Throughput: one request per cycle while dst does not stall.
// When dst stalls with a result waiting, the whole pipeline holds and
// src_stall rises; nothing is dropped or repeated.
// Reset clears all valid bits and the configuration registers to zero.
module aes_ctr_block_cipher (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              src_valid,
    output logic              src_stall,
    input  acbc_pkg::src_req_t src_req,
    output logic              dst_valid,
    input  logic              dst_stall,
    output acbc_pkg::dst_req_t dst_req,
    input  logic              cfg_we,
    input  logic [2:0]        cfg_index,
    input  logic [63:0]       cfg_data
);
    import acbc_pkg::*;

    logic [63:0]  key0_reg, key1_reg, key2_reg, key3_reg, nonce_reg;
    logic [1:0]   mode_reg;
    logic [1:0]   mode;
    logic         en;
    logic [255:0] key;
    stage_t       stage0_next;
    stage_t       stg   [NUM_ROUNDS_MAX+1];
    logic         vld   [NUM_ROUNDS_MAX+1];
    logic         valid0_reg;
    stage_t       stage0_reg;

    assign mode = (mode_reg == 2'd3) ? MODE_256 : mode_reg;
    assign en   = !(dst_valid && dst_stall);
    assign src_stall = !en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key0_reg  <= '0;
            key1_reg  <= '0;
            key2_reg  <= '0;
            key3_reg  <= '0;
            nonce_reg <= '0;
            mode_reg  <= MODE_128;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_KEY0:  key0_reg  <= cfg_data;
                CFG_KEY1:  key1_reg  <= cfg_data;
                CFG_KEY2:  key2_reg  <= cfg_data;
                CFG_KEY3:  key3_reg  <= cfg_data;
                CFG_NONCE: nonce_reg <= cfg_data;
                CFG_MODE:  mode_reg  <= cfg_data[1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        key = {key3_reg, key2_reg, key1_reg, key0_reg};
        stage0_next = '0;
        case (mode)
            MODE_128: stage0_next.kw = {key[127:0], 128'd0};
            MODE_192: stage0_next.kw = {key[191:0], 64'd0};
            default:  stage0_next.kw = key;
        endcase
        stage0_next.kidx    = 3'd0;
        stage0_next.rcon    = 8'h01;
        stage0_next.state   = {nonce_reg, src_req.block_index} ^ round_key(stage0_next.kw, mode);
        stage0_next.data_lo = src_req.data_lo;
        stage0_next.data_hi = src_req.data_hi;
        stage0_next.last    = src_req.last_block;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid0_reg <= 1'b0;
        else if (en)
            valid0_reg <= src_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            stage0_reg <= stage0_next;
    end

    assign vld[0] = valid0_reg;
    assign stg[0] = stage0_reg;

    for (genvar r = 1; r <= NUM_ROUNDS_MAX; r++)
    begin : g_round
        acbc_round_stage u_round (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .mode      (mode),
            .round_num (4'(r)),
            .src_valid (vld[r-1]),
            .src_stage (stg[r-1]),
            .dst_valid (vld[r]),
            .dst_stage (stg[r])
        );
    end

    assign dst_valid        = vld[NUM_ROUNDS_MAX];
    assign dst_req.out_lo   = stg[NUM_ROUNDS_MAX].data_lo ^ stg[NUM_ROUNDS_MAX].state[63:0];
    assign dst_req.out_hi   = stg[NUM_ROUNDS_MAX].data_hi ^ stg[NUM_ROUNDS_MAX].state[127:64];
    assign dst_req.out_last = stg[NUM_ROUNDS_MAX].last;

endmodule

// ===== rtl/acbc_checker.sv =====
// Port-level checks for the AES counter-mode block, bound to the top level.
`include "aes_ctr_block_cipher_macros.svh"

module acbc_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              src_stall,
    input logic              dst_valid,
    input logic              dst_stall,
    input acbc_pkg::dst_req_t dst_req
);
    `ACBC_ASSERT_NEXT(a_dst_valid_holds, dst_valid && dst_stall, dst_valid)
    `ACBC_ASSERT_NEXT(a_dst_req_holds, dst_valid && dst_stall, $stable(dst_req))
    `ACBC_ASSERT_NOW(a_stall_only_on_backpressure, src_stall, dst_valid && dst_stall)
    `ACBC_ASSERT_NOW(a_backpressure_stalls_src, dst_valid && dst_stall, src_stall)

endmodule

bind aes_ctr_block_cipher acbc_checker u_acbc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .src_stall (src_stall),
    .dst_valid (dst_valid),
    .dst_stall (dst_stall),
    .dst_req   (dst_req)
);
